// ===== sv/cvf_pkg.sv =====
// Shared constants and types for the 3x3 convolution filter.
package cvf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int COORD_W    = 10;
  localparam int DIM_W      = 11;
  localparam int KROW_W     = 24;
  localparam int CFG_IDX_W  = 3;

  localparam logic [DIM_W-1:0] MIN_DIM   = DIM_W'(3);
  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_KERNEL_ROW0  = 3'd2,
    REG_KERNEL_ROW1  = 3'd3,
    REG_KERNEL_ROW2  = 3'd4,
    REG_SCALING_MODE = 3'd5
  } cfg_reg_t;

  // Scaling modes; the unused code behaves as the mean.
  typedef enum logic [1:0] {
    MODE_MEAN  = 2'd0,
    MODE_GAUSS = 2'd1,
    MODE_SOBEL = 2'd2
  } scale_mode_t;

  // Position and flags that travel with one word down the pipeline.
  typedef struct packed {
    logic                emit;
    logic                last;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
  } tag_t;

endpackage

// ===== sv/cvf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cvf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/conv3x3_filter_with_scaling.sv =====
// Top level of the streaming 3x3 convolution filter with scaling and clamp.
//
// Usage:
//   Source pixels enter on the input channel (in_valid / in_stall / pixel) in
//   raster order, one word per pixel. Results leave on the output channel
//   (out_valid / out_stall / out_row, out_col, value, last). Only interior
//   pixels of the image cropped to multiples of 3 produce a word; last marks
//   the final interior pixel of a frame.
//   Configuration goes through cfg_write / cfg_index / cfg_data while the
//   filter is idle; derived sizes are registered from the written values.
// Timing:
//   Throughput is one pixel per clock while out_stall is low, set by the
//   single line-store RAM: one read per pixel at acceptance and one
//   write-back in the following stage.
// Reset (rst, synchronous): frame counters, window and pipeline valids clear
//   and registers take their defaults (640x480, box kernel, mean scaling).
//   The line store is not cleared: the first two rows of a frame fill it
//   before any word depends on it.
// Stall: out_stall holds the output register; stages behind it keep taking
//   words until the pipeline is full, then in_stall rises.
module conv3x3_filter_with_scaling
  import cvf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KROW_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COORD_W-1:0]   out_row,
  output logic [COORD_W-1:0]   out_col,
  output logic [7:0]           value,
  output logic                 last
);

  // Configuration registers
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [KROW_W-1:0] kernel_row0;
  logic [KROW_W-1:0] kernel_row1;
  logic [KROW_W-1:0] kernel_row2;
  logic [1:0]        scaling_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(640);
      image_height <= DIM_W'(480);
      kernel_row0  <= KROW_W'(65793);
      kernel_row1  <= KROW_W'(65793);
      kernel_row2  <= KROW_W'(65793);
      scaling_mode <= MODE_MEAN;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        REG_KERNEL_ROW0:  kernel_row0  <= cfg_data;
        REG_KERNEL_ROW1:  kernel_row1  <= cfg_data;
        REG_KERNEL_ROW2:  kernel_row2  <= cfg_data;
        REG_SCALING_MODE: scaling_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Derived frame sizes: clamp to 3..max, then crop down to a multiple of 3.
  // floor(x/3) for x <= 1024 is (x*683) >> 11.
  logic [DIM_W-1:0]   w_clamp, h_clamp;
  logic [DIM_W+9:0]   w_prod, h_prod;
  logic [DIM_W-1:0]   w_eff, h_eff, ow, oh;

  always_comb begin
    if (image_width < MIN_DIM) begin
      w_clamp = MIN_DIM;
    end else if (image_width > MAX_W_DIM) begin
      w_clamp = MAX_W_DIM;
    end else begin
      w_clamp = image_width;
    end
    if (image_height < MIN_DIM) begin
      h_clamp = MIN_DIM;
    end else if (image_height > MAX_H_DIM) begin
      h_clamp = MAX_H_DIM;
    end else begin
      h_clamp = image_height;
    end
    w_prod = (DIM_W+10)'(w_clamp) * (DIM_W+10)'(683);
    h_prod = (DIM_W+10)'(h_clamp) * (DIM_W+10)'(683);
  end

  always_ff @(posedge clk) begin
    w_eff <= w_clamp;
    h_eff <= h_clamp;
    ow    <= DIM_W'(w_prod[DIM_W+9:11]) * DIM_W'(3);
    oh    <= DIM_W'(h_prod[DIM_W+9:11]) * DIM_W'(3);
  end

  // Pipeline handshake: a stage moves on when the one ahead is empty or moving.
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic accept;

  assign rdy6     = !out_valid || !out_stall;
  assign rdy5     = !v5 || rdy6;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;

  // Frame position of the incoming word. Wrap first in case a smaller size
  // was configured since the last word.
  logic [ADDR_W-1:0]  row_cnt, col_cnt;
  logic               col_over;
  logic [DIM_W-1:0]   r_pre;
  logic [ADDR_W-1:0]  cur_r, cur_c;
  logic [DIM_W-1:0]   c_inc, r_inc;
  tag_t               tag_in;

  always_comb begin
    col_over = {1'b0, col_cnt} >= w_eff;
    cur_c    = col_over ? '0 : col_cnt;
    r_pre    = col_over ? DIM_W'(row_cnt) + DIM_W'(1) : DIM_W'(row_cnt);
    cur_r    = (r_pre >= h_eff) ? '0 : r_pre[ADDR_W-1:0];
    c_inc    = DIM_W'(cur_c) + DIM_W'(1);
    r_inc    = DIM_W'(cur_r) + DIM_W'(1);

    tag_in.emit = (cur_r >= ADDR_W'(2)) && (DIM_W'(cur_r) < oh) &&
                  (cur_c >= ADDR_W'(2)) && (DIM_W'(cur_c) < ow);
    tag_in.last = (DIM_W'(cur_r) + DIM_W'(1) == oh) &&
                  (DIM_W'(cur_c) + DIM_W'(1) == ow);
    tag_in.row  = COORD_W'(cur_r - ADDR_W'(1));
    tag_in.col  = COORD_W'(cur_c - ADDR_W'(1));
  end

  // Advance the counters; wrap column, then row.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (accept) begin
      if (c_inc >= w_eff) begin
        col_cnt <= '0;
        row_cnt <= (r_inc >= h_eff) ? '0 : r_inc[ADDR_W-1:0];
      end else begin
        col_cnt <= c_inc[ADDR_W-1:0];
        row_cnt <= cur_r;
      end
    end
  end

  // Line store: one entry per column holds {middle row, top row}.
  // Read at acceptance, write back as the word leaves stage 1. A column is
  // revisited only a full row (at least 3 words) later, so no forwarding.
  logic              go1;
  logic [7:0]        px1;
  logic [ADDR_W-1:0] col1;
  tag_t              tag1;
  logic [15:0]       ls_rdata;
  logic [7:0]        top1, mid1;

  assign go1  = v1 && rdy2;
  assign top1 = ls_rdata[7:0];
  assign mid1 = ls_rdata[15:8];

  cvf_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (go1),
    .waddr (col1),
    .wdata ({px1, mid1}),
    .re    (accept),
    .raddr (cur_c),
    .rdata (ls_rdata)
  );

  // 3x3 window: win[i][j], i top..bottom, j oldest..newest column.
  logic [7:0] win [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (go1) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= top1;
      win[1][2] <= mid1;
      win[2][2] <= px1;
    end
  end

  // Stage 2 reads the window (it holds while stage 2 waits), stage 3 holds
  // the nine products, stage 4 the row sums, stage 5 the total, and the
  // output register the scaled value.
  logic go2, go3, go4, go5;
  assign go2 = v2 && rdy3;
  assign go3 = v3 && rdy4;
  assign go4 = v4 && rdy5;
  assign go5 = v5 && rdy6;

  tag_t tag2, tag3, tag4, tag5;
  logic signed [16:0] prod3 [3][3];
  logic signed [18:0] rsum4 [3];
  logic signed [20:0] sum5;
  logic [KROW_W-1:0]  krow [3];

  assign krow[0] = kernel_row0;
  assign krow[1] = kernel_row1;
  assign krow[2] = kernel_row2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= go1;
      if (rdy3) v3 <= go2;
      if (rdy4) v4 <= go3;
      if (rdy5) v5 <= go4;
      // Drop words that fall outside the interior: they only shift the window.
      if (rdy6) out_valid <= go5 && tag5.emit;
    end
  end

  // Scaling of the total: each mode truncates, then clamps to 0..255.
  // sum/9 below 2304 is (sum*7282) >> 16; at or above it clamps anyway.
  logic signed [20:0] sob_t;
  logic [24:0]        mean_prod;
  logic [7:0]         scaled;

  always_comb begin
    sob_t     = sum5 + 21'sd1020;
    mean_prod = 25'(sum5[11:0]) * 25'(7282);
    case (scaling_mode)
      MODE_SOBEL: begin
        if (sob_t < 0) begin
          scaled = '0;
        end else if (sob_t[19:3] > 17'd255) begin
          scaled = 8'd255;
        end else begin
          scaled = sob_t[10:3];
        end
      end
      MODE_GAUSS: begin
        if (sum5 < 0) begin
          scaled = '0;
        end else if (sum5[19:4] > 16'd255) begin
          scaled = 8'd255;
        end else begin
          scaled = sum5[11:4];
        end
      end
      default: begin
        if (sum5 < 0) begin
          scaled = '0;
        end else if (sum5 >= 21'sd2304) begin
          scaled = 8'd255;
        end else begin
          scaled = mean_prod[23:16];
        end
      end
    endcase
  end

  // Payload registers: load when the stage takes a word, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      px1  <= pixel;
      col1 <= cur_c;
      tag1 <= tag_in;
    end
    if (go1) begin
      tag2 <= tag1;
    end
    if (go2) begin
      tag3 <= tag2;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod3[i][j] <= $signed({1'b0, win[i][j]}) * $signed(krow[i][8*j +: 8]);
        end
      end
    end
    if (go3) begin
      tag4 <= tag3;
      for (int i = 0; i < 3; i++) begin
        rsum4[i] <= 19'(prod3[i][0]) + 19'(prod3[i][1]) + 19'(prod3[i][2]);
      end
    end
    if (go4) begin
      tag5 <= tag4;
      sum5 <= 21'(rsum4[0]) + 21'(rsum4[1]) + 21'(rsum4[2]);
    end
    if (go5 && tag5.emit) begin
      out_row <= tag5.row;
      out_col <= tag5.col;
      last    <= tag5.last;
      value   <= scaled;
    end
  end

endmodule
